/* rtl/iopd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopd_pkg
// Shared types and constants for the injector overlap pulse driver.
// ----------------------------------------------------------------------------
package iopd_pkg;

	localparam int KIND_W  = 3;
	localparam int CH_W    = 4;
	localparam int DUR_W   = 17;
	localparam int PIN_W   = 12;
	localparam int OCNT_W  = 8;
	localparam int TIME_W  = 64;
	localparam int REQ_W   = 32;
	localparam int CYL_W   = 4;

	localparam logic [DUR_W-1:0] DUR_MIN_US    = DUR_W'(1);
	localparam logic [DUR_W-1:0] DUR_MAX_US    = DUR_W'(100000);
	localparam logic [CYL_W-1:0] CYL_RESET_VAL = CYL_W'(4);

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK      = 3'd0,
		KIND_OPEN      = 3'd1,
		KIND_CLOSE     = 3'd2,
		KIND_TIMED     = 3'd3,
		KIND_OPEN_ALL  = 3'd4,
		KIND_CLOSE_ALL = 3'd5
	} kind_t;

	// decoded command broadcast to every channel lane, already qualified by transfer
	typedef struct packed {
		logic             tick;
		logic             open;
		logic             close;
		logic             timed;
		logic             open_all;
		logic             close_all;
		logic             dur_ok;
		logic [CH_W-1:0]  ch;
		logic [CYL_W-1:0] cyl;
	} cmd_t;

endpackage

/* rtl/injector_overlap_pulse_driver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// injector_overlap_pulse_driver
// Bank of injector channels with overlap counting, timed opens and tick timer.
// ----------------------------------------------------------------------------
// One result per item, one item per cycle sustained while out_ready is held high. An item
// is captured in an input register (duration scaled to ticks there); once the output
// register can accept it, all channel lanes update in parallel and the result lands in
// the output register. The per-cycle limit is the lane update: a 64-bit end-time add
// and compare for timed opens, and the parallel 64-bit due compares of every channel on
// a tick.
module injector_overlap_pulse_driver #(
	parameter int MAX_CHANNELS = 12,
	parameter int TICKS_PER_US = 100
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [iopd_pkg::CYL_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [iopd_pkg::KIND_W-1:0]  kind,
	input  logic [iopd_pkg::CH_W-1:0]    channel,
	input  logic [iopd_pkg::DUR_W-1:0]   duration_us,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [iopd_pkg::PIN_W-1:0]   pin_levels,
	output logic [iopd_pkg::REQ_W-1:0]   injection_count,
	output logic                         rejected
);

	localparam int PROD_W = iopd_pkg::DUR_W + $clog2(TICKS_PER_US + 1);
	localparam int GRP_W  = iopd_pkg::CH_W + 1;

	logic [iopd_pkg::CYL_W-1:0]  cyl_q;
	logic                        valid_s1;
	iopd_pkg::kind_t             kind_s1;
	logic [iopd_pkg::CH_W-1:0]   ch_s1;
	logic [PROD_W-1:0]           prod_s1;
	logic                        dur_ok_s1;
	logic                        advance, fire;
	logic [iopd_pkg::TIME_W-1:0] now_q, now_next, desired;
	logic [iopd_pkg::REQ_W-1:0]  req_q, req_d;
	logic [GRP_W-1:0]            grp, inc;
	logic                        ch_ok, rej_d;
	iopd_pkg::cmd_t              cmd;
	logic [MAX_CHANNELS-1:0]     lvl_d;
	logic [iopd_pkg::PIN_W-1:0]  pins_d;
	logic                        out_valid_q, rejected_q;
	logic [iopd_pkg::PIN_W-1:0]  pin_levels_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_q <= iopd_pkg::CYL_RESET_VAL;
		end else if (cfg_we) begin
			cyl_q <= cfg_wdata;
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1   <= iopd_pkg::kind_t'(kind);
			ch_s1     <= channel;
			prod_s1   <= PROD_W'(duration_us) * PROD_W'(TICKS_PER_US);
			dur_ok_s1 <= (duration_us >= iopd_pkg::DUR_MIN_US)
			             && (duration_us <= iopd_pkg::DUR_MAX_US);
		end
	end

	assign ch_ok    = ({1'b0, ch_s1} < GRP_W'(MAX_CHANNELS));
	assign now_next = now_q + iopd_pkg::TIME_W'(1);
	assign desired  = now_q + iopd_pkg::TIME_W'(prod_s1);
	assign grp      = ({1'b0, cyl_q} > GRP_W'(MAX_CHANNELS)) ? GRP_W'(MAX_CHANNELS)
	                                                         : {1'b0, cyl_q};

	always_comb begin
		cmd        = '0;
		cmd.ch     = ch_s1;
		cmd.cyl    = cyl_q;
		cmd.dur_ok = dur_ok_s1;
		inc        = '0;
		rej_d      = 1'b0;
		if (fire) begin
			case (kind_s1)
				iopd_pkg::KIND_TICK: begin
					cmd.tick = 1'b1;
				end
				iopd_pkg::KIND_OPEN: begin
					cmd.open = ch_ok;
					inc      = GRP_W'(ch_ok);
				end
				iopd_pkg::KIND_CLOSE: begin
					cmd.close = ch_ok;
				end
				iopd_pkg::KIND_TIMED: begin
					cmd.timed = ch_ok;
					inc       = GRP_W'(ch_ok);
					rej_d     = ch_ok && !dur_ok_s1;
				end
				iopd_pkg::KIND_OPEN_ALL: begin
					cmd.open_all = 1'b1;
					inc          = grp;
				end
				iopd_pkg::KIND_CLOSE_ALL: begin
					cmd.close_all = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign req_d = req_q + iopd_pkg::REQ_W'(inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			req_q <= '0;
		end else begin
			if (cmd.tick) begin
				now_q <= now_next;
			end
			req_q <= req_d;
		end
	end

	for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
		iopd_lane #(
			.LANE_IDX(i)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.now_next (now_next),
			.desired  (desired),
			.level_d  (lvl_d[i])
		);
	end

	for (genvar i = 0; i < iopd_pkg::PIN_W; i++) begin : g_pin
		if (i < MAX_CHANNELS) begin : g_on
			assign pins_d[i] = lvl_d[i];
		end else begin : g_off
			assign pins_d[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pin_levels_q    <= pins_d;
			injection_count <= req_d;
			rejected_q      <= rej_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign pin_levels = pin_levels_q;
	assign rejected   = rejected_q;

	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind_s1 == iopd_pkg::KIND_TICK) |=> (now_q == $past(now_q) + 1'b1))
		else $error("tick did not advance time by one");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> (req_q == $past(req_q)))
		else $error("request count moved without a transfer");

	a_rej_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rej_d) |=> (out_valid_q && rejected_q
		                     && injection_count == $past(req_q) + 1'b1
		                     && pin_levels_q == $past(pin_levels_q)
		                     || !$past(out_valid_q)))
		else $error("rejected timed open result inconsistent");

endmodule

/* rtl/iopd_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopd_lane
// One injector channel: overlap count, pending end time and due compare.
// ----------------------------------------------------------------------------
module iopd_lane #(
	parameter int LANE_IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  iopd_pkg::cmd_t              cmd,
	input  logic [iopd_pkg::TIME_W-1:0] now_next,
	input  logic [iopd_pkg::TIME_W-1:0] desired,
	output logic                        level_d
);

	logic [iopd_pkg::OCNT_W-1:0] cnt_q, cnt_d, cnt_dec;
	logic                        pend_q, pend_d;
	logic [iopd_pkg::TIME_W-1:0] end_q, end_d;
	logic                        sel_one, in_grp, due;
	logic                        do_open, do_close, do_timed;

	assign sel_one  = (cmd.ch == iopd_pkg::CH_W'(LANE_IDX));
	assign in_grp   = (iopd_pkg::CH_W'(LANE_IDX) < cmd.cyl);
	assign due      = pend_q && (now_next >= end_q);
	assign do_open  = (cmd.open && sel_one) || (cmd.open_all && in_grp);
	assign do_close = (cmd.close && sel_one) || (cmd.close_all && in_grp) || (cmd.tick && due);
	assign do_timed = cmd.timed && sel_one && cmd.dur_ok;
	assign cnt_dec  = (cnt_q == '0) ? '0 : cnt_q - 1'b1;

	always_comb begin
		cnt_d  = cnt_q;
		pend_d = pend_q;
		end_d  = end_q;
		if (do_open) begin
			cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
		end else if (do_close) begin
			cnt_d = cnt_dec;
			if (cnt_dec == '0 || cmd.tick) begin
				pend_d = 1'b0;
			end
		end else if (do_timed) begin
			if (cnt_q != '0) begin
				if (!pend_q || desired > end_q) begin
					end_d  = desired;
					pend_d = 1'b1;
				end
			end else begin
				cnt_d  = iopd_pkg::OCNT_W'(1);
				end_d  = desired;
				pend_d = 1'b1;
			end
		end
	end

	assign level_d = (cnt_d != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		end_q <= end_d;
	end

	// pending close only exists on an open channel
	a_pend_open: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (cnt_q != '0))
		else $error("pending end time on a closed channel");

	// a due tick always consumes the pending close
	a_due_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick && due) |=> (!pend_q || $past(cnt_q) > iopd_pkg::OCNT_W'(1)) && !pend_q)
		else $error("due tick left end time pending");

endmodule
